[hdl/spdl_pkg.sv]
// ----------------------------------------------------------------------------
// spdl_pkg
// Shared types and constants of the scanned presence detector / LED driver.
// ----------------------------------------------------------------------------
package spdl_pkg;

  // Fixed field widths
  localparam int FIELD_W = 12;
  localparam int EMIT_W  = 4;
  localparam int LIMIT_W = 8;
  localparam int DWELL_W = 8;
  localparam int FLASH_W = 16;
  localparam int MISM_W  = 8;
  localparam int CODE_W  = 3;

  // Configuration defaults
  localparam logic [LIMIT_W-1:0] DEBOUNCE_RST = 8'd100;
  localparam logic [DWELL_W-1:0] DWELL_RST    = 8'd50;
  localparam logic [FLASH_W-1:0] FLASH_RST    = 16'd500;

  // LED level encoding: bit0 red, bit1 green
  localparam logic [1:0] LVL_OFF   = 2'b00;
  localparam logic [1:0] LVL_RED   = 2'b01;
  localparam logic [1:0] LVL_GREEN = 2'b10;

  // Manual pattern codes (6 and 7 hold the current levels)
  typedef enum logic [CODE_W-1:0] {
    PAT_OFF,
    PAT_RED,
    PAT_GREEN,
    PAT_RED_FLASH,
    PAT_GREEN_FLASH,
    PAT_ALTERNATE
  } pattern_t;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_MODE_MASK,
    REG_PATTERN,
    REG_REPORT_EN,
    REG_DEBOUNCE,
    REG_DWELL,
    REG_FLASH
  } reg_idx_t;

  // Per-lane control for one word
  typedef struct packed {
    logic               tick;
    logic               poll;
    logic               level;
    logic               manual;
    pattern_t           code;
    logic               report_en;
    logic [LIMIT_W-1:0] limit;
    logic [FLASH_W-1:0] flash_reload;
  } lane_ctl_t;

  // Per-lane status after one word
  typedef struct packed {
    logic presence;
    logic red;
    logic green;
    logic report;
  } lane_stat_t;

  // Result word, last field in the lowest bits
  typedef struct packed {
    logic               rep_present;
    logic [EMIT_W-1:0]  rep_channel;
    logic               rep_valid;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] presence;
    logic [EMIT_W-1:0]  emitter;
  } result_t;

  localparam int RES_W   = $bits(result_t);
  localparam int OUT_D_W = ((RES_W + 7) / 8) * 8;

endpackage

[hdl/spdl_lane.sv]
// ----------------------------------------------------------------------------
// spdl_lane
// One channel: debounce of the receiver level and the red/green LED driver.
// ----------------------------------------------------------------------------
module spdl_lane
  import spdl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  lane_ctl_t  ctl,
  output lane_stat_t stat
);

  logic [MISM_W-1:0]  mc_r, mc_nxt, mc_inc;
  logic               stable_r, stable_nxt;
  logic               settled_r, settled_nxt;
  logic               phase_r, phase_nxt;
  logic [FLASH_W-1:0] fc_r, fc_nxt, fc_tick;
  logic [1:0]         led_r, led_nxt;
  logic               toggled;
  logic               report;

  // Debounce the polled level
  always_comb begin
    mc_inc      = mc_r + 1'b1;
    mc_nxt      = mc_r;
    stable_nxt  = stable_r;
    settled_nxt = settled_r;
    report      = 1'b0;
    if (ctl.poll) begin
      if (ctl.level != stable_r) begin
        if (mc_inc >= ctl.limit) begin
          stable_nxt  = ctl.level;
          report      = ctl.report_en & settled_r;
          settled_nxt = 1'b1;
          mc_nxt      = '0;
        end else begin
          mc_nxt = mc_inc;
        end
      end else begin
        mc_nxt = '0;
      end
    end
  end

  // Age the flash timer, then drive the LEDs
  always_comb begin
    fc_tick   = (ctl.tick && fc_r != '0) ? fc_r - 1'b1 : fc_r;
    fc_nxt    = fc_tick;
    phase_nxt = phase_r;
    led_nxt   = led_r;
    toggled   = ~phase_r;
    if (!ctl.manual) begin
      led_nxt = stable_nxt ? LVL_GREEN : LVL_RED;
    end else begin
      case (ctl.code)
        PAT_OFF:   led_nxt = LVL_OFF;
        PAT_RED:   led_nxt = LVL_RED;
        PAT_GREEN: led_nxt = LVL_GREEN;
        PAT_RED_FLASH, PAT_GREEN_FLASH, PAT_ALTERNATE: begin
          if (fc_tick == '0) begin
            phase_nxt = toggled;
            fc_nxt    = ctl.flash_reload;
            if (ctl.code == PAT_RED_FLASH) begin
              led_nxt = toggled ? LVL_RED : LVL_OFF;
            end else if (ctl.code == PAT_GREEN_FLASH) begin
              led_nxt = toggled ? LVL_GREEN : LVL_OFF;
            end else begin
              led_nxt = toggled ? LVL_GREEN : LVL_RED;
            end
          end
        end
        default: led_nxt = led_r;
      endcase
    end
  end

  // Commit on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mc_r      <= '0;
      stable_r  <= 1'b0;
      settled_r <= 1'b0;
      phase_r   <= 1'b0;
      fc_r      <= '0;
      led_r     <= LVL_OFF;
    end else if (advance) begin
      mc_r      <= mc_nxt;
      stable_r  <= stable_nxt;
      settled_r <= settled_nxt;
      phase_r   <= phase_nxt;
      fc_r      <= fc_nxt;
      led_r     <= led_nxt;
    end
  end

  assign stat.presence = stable_nxt;
  assign stat.red      = led_nxt[0];
  assign stat.green    = led_nxt[1];
  assign stat.report   = report;

endmodule

[hdl/spdl_oq.sv]
// ----------------------------------------------------------------------------
// spdl_oq
// Two-entry output buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module spdl_oq
  import spdl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    out_v_r, out_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop = out_v_r & out_ready;

  // Move words from skid to output, or straight in
  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_nxt    = skid_r;
        skid_v_nxt = push;
        skid_nxt   = push_data;
      end else begin
        out_v_nxt = push;
        out_nxt   = push_data;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign ready     = ~skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

[hdl/scanned_presence_detector_led_driver_unit.sv]
// ----------------------------------------------------------------------------
// scanned_presence_detector_led_driver_unit
// Scanned presence detector with per-channel red/green LED driver.
// ----------------------------------------------------------------------------
// The unit takes one input word per clock when the output buffer has room and
// gives a result word for each. Every channel has its own lane that debounces
// the polled receiver level and runs the LED pattern, all lanes in the same
// cycle; a merging stage gathers presence, LED levels and the change report.
// A two-word output buffer keeps input acceptance going for one more word
// while a result waits downstream. The scan index and dwell timer sit here.
// ----------------------------------------------------------------------------
module scanned_presence_detector_led_driver_unit
  import spdl_pkg::*;
#(
  parameter int CHANNELS = 12
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  // in_tdata: receiver_pins[11:0], zero pad
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,
  // in_tuser: poll[0], ms_tick[1]
  input  logic [1:0]           in_tuser,
  // out_tdata: active_emitter[3:0], presence_mask[15:4], red_leds[27:16],
  // green_leds[39:28], report_valid[40], report_channel[44:41],
  // report_present[45], zero pad
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_D_W-1:0]   out_tdata,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [5:0]           cfg_paddr,
  input  logic [63:0]          cfg_pwdata,
  output logic [63:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam int IDX_W = $clog2(CHANNELS);

  // Configuration registers
  logic [FIELD_W-1:0]        mode_r;
  logic [CODE_W*FIELD_W-1:0] pattern_r;
  logic                      report_en_r;
  logic [LIMIT_W-1:0]        limit_r;
  logic [DWELL_W-1:0]        dwell_ms_r;
  logic [FLASH_W-1:0]        flash_r;
  reg_idx_t                  cfg_idx;
  logic                      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[5:3]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= '0;
      pattern_r   <= '0;
      report_en_r <= 1'b0;
      limit_r     <= DEBOUNCE_RST;
      dwell_ms_r  <= DWELL_RST;
      flash_r     <= FLASH_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE_MASK: mode_r      <= cfg_pwdata[FIELD_W-1:0];
        REG_PATTERN:   pattern_r   <= cfg_pwdata[CODE_W*FIELD_W-1:0];
        REG_REPORT_EN: report_en_r <= cfg_pwdata[0];
        REG_DEBOUNCE:  limit_r     <= cfg_pwdata[LIMIT_W-1:0];
        REG_DWELL:     dwell_ms_r  <= cfg_pwdata[DWELL_W-1:0];
        REG_FLASH:     flash_r     <= cfg_pwdata[FLASH_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      REG_MODE_MASK: cfg_prdata = 64'(mode_r);
      REG_PATTERN:   cfg_prdata = 64'(pattern_r);
      REG_REPORT_EN: cfg_prdata = 64'(report_en_r);
      REG_DEBOUNCE:  cfg_prdata = 64'(limit_r);
      REG_DWELL:     cfg_prdata = 64'(dwell_ms_r);
      REG_FLASH:     cfg_prdata = 64'(flash_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // Input word
  logic               in_acc;
  logic               poll, tick;
  logic [FIELD_W-1:0] pins;

  assign in_acc = in_tvalid & in_tready;
  assign pins   = in_tdata[FIELD_W-1:0];
  assign poll   = in_tuser[0];
  assign tick   = in_tuser[1];

  // Scan index and dwell timer
  logic [IDX_W-1:0]   scan_r, scan_nxt;
  logic [DWELL_W-1:0] dwell_r, dwell_nxt, dwell_tick;
  logic               dwell_done;

  always_comb begin
    dwell_tick = (tick && dwell_r != '0) ? dwell_r - 1'b1 : dwell_r;
    dwell_done = poll & (dwell_tick == '0);
    dwell_nxt  = dwell_tick;
    scan_nxt   = scan_r;
    if (dwell_done) begin
      dwell_nxt = dwell_ms_r;
      scan_nxt  = (32'(scan_r) + 1 >= CHANNELS) ? '0 : scan_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r  <= '0;
      dwell_r <= '0;
    end else if (in_acc) begin
      scan_r  <= scan_nxt;
      dwell_r <= dwell_nxt;
    end
  end

  // Channel lanes
  logic [CHANNELS-1:0] pres_v, red_v, green_v, rep_v;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    lane_ctl_t  ctl;
    lane_stat_t stat;

    assign ctl.tick         = tick;
    assign ctl.poll         = poll && (scan_r == IDX_W'(i));
    assign ctl.report_en    = report_en_r;
    assign ctl.limit        = limit_r;
    assign ctl.flash_reload = flash_r;

    if (i < FIELD_W) begin : g_field
      assign ctl.level  = pins[i];
      assign ctl.manual = mode_r[i];
      assign ctl.code   = pattern_t'(pattern_r[CODE_W*i +: CODE_W]);
    end else begin : g_beyond
      assign ctl.level  = 1'b0;
      assign ctl.manual = 1'b0;
      assign ctl.code   = PAT_OFF;
    end

    spdl_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (in_acc),
      .ctl     (ctl),
      .stat    (stat)
    );

    assign pres_v[i]  = stat.presence;
    assign red_v[i]   = stat.red;
    assign green_v[i] = stat.green;
    assign rep_v[i]   = stat.report;
  end

  // Merge lane results
  result_t res;
  logic    rep_any;

  assign rep_any         = |rep_v;
  assign res.emitter     = EMIT_W'(scan_nxt);
  assign res.presence    = FIELD_W'(pres_v);
  assign res.red         = FIELD_W'(red_v);
  assign res.green       = FIELD_W'(green_v);
  assign res.rep_valid   = rep_any;
  assign res.rep_channel = rep_any ? EMIT_W'(scan_r) : '0;
  assign res.rep_present = |(rep_v & pres_v);

  // Output buffer
  result_t out_res;

  spdl_oq u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_data (res),
    .ready     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = OUT_D_W'(out_res);

  // Checks
  a_one_report: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(rep_v))
    else $error("more than one lane reported a change");

  a_report_needs_poll: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && rep_any |-> poll && report_en_r)
    else $error("change report without poll or with reporting off");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(scan_r) < CHANNELS)
    else $error("scan index out of range");

  a_scan_moves: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && dwell_done |=> scan_r != $past(scan_r))
    else $error("emitter did not advance on dwell expiry");

endmodule
